### hw/rtl/positional_list_engine_assert.svh
// assertion macros for the positional list engine
// expects clk_i and rst_ni in the scope of the including module
`ifndef POSITIONAL_LIST_ENGINE_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define PLE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define PLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/ple_pkg.sv
// shared types and constants of the positional list engine
// no dependencies
`timescale 1ns / 1ps

package ple_pkg;

  // store size and derived widths
  localparam int CAPACITY = 64;
  localparam int CELL_W   = $clog2(CAPACITY);
  localparam int CNT_W    = 7;
  localparam int POS_W    = 7;
  localparam int OP_W     = 3;
  localparam int ST_W     = 2;
  localparam int DATA_W   = 32;

  // read gather tree: lanes per first-level group
  localparam int GROUP    = 8;
  localparam int NGRP     = (CAPACITY + GROUP - 1) / GROUP;

  typedef enum logic [OP_W-1:0] {
    OP_READ      = 3'd0,
    OP_INS_FRONT = 3'd1,
    OP_INS_END   = 3'd2,
    OP_INS_AT    = 3'd3,
    OP_DELETE    = 3'd4
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_REDUCE
  } state_e;

  // command broadcast to every cell
  typedef struct packed {
    logic                     ins;
    logic                     del;
    logic                     rd;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] value;
  } ple_cmd_t;

endpackage

### hw/rtl/ple_if.sv
// request and response channel interfaces of the positional list engine
// depends on ple_pkg
`timescale 1ns / 1ps

interface ple_req_if;
  logic                              valid;
  logic                              ready;
  logic [ple_pkg::OP_W-1:0]          opcode;
  logic [ple_pkg::POS_W-1:0]         position;
  logic signed [ple_pkg::DATA_W-1:0] value_in;

  modport source (output valid, opcode, position, value_in, input ready);
  modport sink   (input valid, opcode, position, value_in, output ready);
endinterface

interface ple_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [ple_pkg::ST_W-1:0]          status;
  logic signed [ple_pkg::DATA_W-1:0] value_out;
  logic [ple_pkg::CNT_W-1:0]         length;

  modport source (output valid, status, value_out, length, input ready);
  modport sink   (input valid, status, value_out, length, output ready);
endinterface

### hw/rtl/ple_cell.sv
// one storage cell of the element row
// depends on ple_pkg
`timescale 1ns / 1ps

module ple_cell (
  input  logic                              clk_i,
  input  logic [ple_pkg::CELL_W-1:0]        idx_i,
  input  ple_pkg::ple_cmd_t                 cmd_i,
  input  logic signed [ple_pkg::DATA_W-1:0] left_i,
  input  logic signed [ple_pkg::DATA_W-1:0] right_i,
  output logic signed [ple_pkg::DATA_W-1:0] value_o,
  output logic signed [ple_pkg::DATA_W-1:0] rd_o
);

  logic signed [ple_pkg::DATA_W-1:0] value_d, value_q;
  logic [ple_pkg::POS_W-1:0]         idx_ext;

  assign idx_ext = ple_pkg::POS_W'(idx_i);

  // insert moves the tail up, delete pulls it down
  always_comb begin
    value_d = value_q;
    if (cmd_i.ins) begin
      if (idx_ext > cmd_i.pos) begin
        value_d = left_i;
      end else if (idx_ext == cmd_i.pos) begin
        value_d = cmd_i.value;
      end
    end else if (cmd_i.del) begin
      if (idx_ext >= cmd_i.pos) begin
        value_d = right_i;
      end
    end
  end

  // element storage, payload only
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  // read lane: own value when addressed, else zero
  assign value_o = value_q;
  assign rd_o    = (cmd_i.rd && idx_ext == cmd_i.pos) ? value_q : '0;

endmodule

### hw/rtl/ple_row.sv
// row of element cells with a registered read gather tree
// depends on ple_pkg and ple_cell
`timescale 1ns / 1ps

module ple_row (
  input  logic                              clk_i,
  input  ple_pkg::ple_cmd_t                 cmd_i,
  output logic signed [ple_pkg::DATA_W-1:0] rd_data_o
);

  logic signed [ple_pkg::DATA_W-1:0] val   [ple_pkg::CAPACITY];
  logic signed [ple_pkg::DATA_W-1:0] lane  [ple_pkg::CAPACITY];
  logic signed [ple_pkg::DATA_W-1:0] grp_d [ple_pkg::NGRP];
  logic signed [ple_pkg::DATA_W-1:0] grp_q [ple_pkg::NGRP];

  // the cell chain, each linked to both neighbours
  for (genvar g = 0; g < ple_pkg::CAPACITY; g++) begin : g_cell
    logic signed [ple_pkg::DATA_W-1:0] left, right;
    if (g == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = val[g-1];
    end
    if (g == ple_pkg::CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = val[g+1];
    end

    ple_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (ple_pkg::CELL_W'(g)),
      .cmd_i   (cmd_i),
      .left_i  (left),
      .right_i (right),
      .value_o (val[g]),
      .rd_o    (lane[g])
    );
  end

  // first level: or over each group of lanes
  always_comb begin
    for (int g = 0; g < ple_pkg::NGRP; g++) begin
      grp_d[g] = '0;
      for (int k = 0; k < ple_pkg::GROUP; k++) begin
        if (g * ple_pkg::GROUP + k < ple_pkg::CAPACITY) begin
          grp_d[g] = grp_d[g] | lane[g * ple_pkg::GROUP + k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q <= grp_d;
  end

  // second level: or over the group registers
  always_comb begin
    rd_data_o = '0;
    for (int g = 0; g < ple_pkg::NGRP; g++) begin
      rd_data_o = rd_data_o | grp_q[g];
    end
  end

endmodule

### hw/rtl/positional_list_engine.sv
// Positional list engine: an ordered list of up to 64 signed 32-bit values held in a row of
// cells, addressed by position. Each request (read, insert front, insert end, insert before a
// position, delete at a position) returns one beat with status, value read and new length.
// A request passes the idle, execute and reduce states: idle accepts it and checks it against
// the length, in execute every cell shifts or loads at once and the read lanes feed the first
// level of the gather tree, and reduce loads the second level into the output register once free.
// The next request is taken as soon as the response is in the output register,
// even while that beat still waits for the sink. Element storage needs no clearing after reset.
// depends on ple_pkg, ple_if, ple_row and positional_list_engine_assert.svh
`timescale 1ns / 1ps

module positional_list_engine (
  input  logic       clk_i,
  input  logic       rst_ni,
  ple_req_if.sink    req_i,
  ple_rsp_if.source  rsp_o
);

  `include "positional_list_engine_assert.svh"

  ple_pkg::state_e                   state_d, state_q;
  logic [ple_pkg::CNT_W-1:0]         count_d, count_q;
  logic                              ins_d, ins_q, del_d, del_q, rd_d, rd_q;
  logic [ple_pkg::POS_W-1:0]         pos_d, pos_q;
  logic signed [ple_pkg::DATA_W-1:0] val_q;
  ple_pkg::status_e                  st_d, st_q;
  logic                              rsp_valid_d, rsp_valid_q;
  logic [ple_pkg::ST_W-1:0]          rsp_st_q;
  logic signed [ple_pkg::DATA_W-1:0] rsp_val_q;
  logic [ple_pkg::CNT_W-1:0]         rsp_len_q;
  logic                              accept, load, in_ready, in_exec;
  logic                              full, ins_pos_ok;
  logic [ple_pkg::POS_W-1:0]         ins_pos;
  ple_pkg::ple_cmd_t                 cmd;
  logic signed [ple_pkg::DATA_W-1:0] rd_data;

  assign accept = req_i.valid && in_ready;
  assign full   = (count_q == ple_pkg::CNT_W'(ple_pkg::CAPACITY));

  // insert position for the three insert flavours
  always_comb begin
    case (ple_pkg::op_e'(req_i.opcode))
      ple_pkg::OP_INS_FRONT: ins_pos = '0;
      ple_pkg::OP_INS_END:   ins_pos = ple_pkg::POS_W'(count_q);
      default:               ins_pos = req_i.position;
    endcase
  end
  assign ins_pos_ok = (ins_pos <= ple_pkg::POS_W'(count_q));

  // request decode: status, cell command and new length
  always_comb begin
    st_d    = ple_pkg::ST_DONE;
    ins_d   = 1'b0;
    del_d   = 1'b0;
    rd_d    = 1'b0;
    pos_d   = req_i.position;
    count_d = count_q;
    case (ple_pkg::op_e'(req_i.opcode))
      ple_pkg::OP_READ: begin
        if (req_i.position < ple_pkg::POS_W'(count_q)) begin
          rd_d = 1'b1;
        end else begin
          st_d = ple_pkg::ST_RANGE;
        end
      end
      ple_pkg::OP_INS_FRONT, ple_pkg::OP_INS_END, ple_pkg::OP_INS_AT: begin
        pos_d = ins_pos;
        if (!ins_pos_ok) begin
          st_d = ple_pkg::ST_RANGE;
        end else if (full) begin
          st_d = ple_pkg::ST_FULL;
        end else begin
          ins_d   = 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      ple_pkg::OP_DELETE: begin
        if (req_i.position < ple_pkg::POS_W'(count_q)) begin
          del_d   = 1'b1;
          count_d = count_q - 1'b1;
        end else begin
          st_d = ple_pkg::ST_RANGE;
        end
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ple_pkg::S_IDLE:   if (req_i.valid) state_d = ple_pkg::S_EXEC;
      ple_pkg::S_EXEC:   state_d = ple_pkg::S_REDUCE;
      ple_pkg::S_REDUCE: if (!rsp_valid_q || rsp_o.ready) state_d = ple_pkg::S_IDLE;
      default:           state_d = ple_pkg::S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    in_exec  = 1'b0;
    load     = 1'b0;
    case (state_q)
      ple_pkg::S_IDLE:   in_ready = 1'b1;
      ple_pkg::S_EXEC:   in_exec  = 1'b1;
      ple_pkg::S_REDUCE: load     = !rsp_valid_q || rsp_o.ready;
      default: ;
    endcase
  end

  assign req_i.ready = in_ready;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ple_pkg::S_IDLE;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  // captured request
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ins_q <= ins_d;
      del_q <= del_d;
      rd_q  <= rd_d;
      pos_q <= pos_d;
      val_q <= req_i.value_in;
      st_q  <= st_d;
    end
  end

  // shifts reach the cells only in the execute cycle; the read lane stays
  // selected so the gathered value holds while the output register is blocked
  always_comb begin
    cmd.ins   = in_exec && ins_q;
    cmd.del   = in_exec && del_q;
    cmd.rd    = rd_q;
    cmd.pos   = pos_q;
    cmd.value = val_q;
  end

  ple_row u_row (
    .clk_i     (clk_i),
    .cmd_i     (cmd),
    .rd_data_o (rd_data)
  );

  // output register
  assign rsp_valid_d = load || (rsp_valid_q && !rsp_o.ready);

  always_ff @(posedge clk_i) begin
    if (load) begin
      rsp_st_q  <= st_q;
      rsp_val_q <= rd_q ? rd_data : '0;
      rsp_len_q <= count_q;
    end
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.status    = rsp_st_q;
  assign rsp_o.value_out = rsp_val_q;
  assign rsp_o.length    = rsp_len_q;

  // checks
  `PLE_ASSERT_NOW(a_count_cap, 1'b1, count_q <= ple_pkg::CNT_W'(ple_pkg::CAPACITY),
    "element count above capacity")
  `PLE_ASSERT_NEXT(a_ins_grows, accept && ins_d, count_q == $past(count_q) + 1'b1,
    "accepted insert did not grow the list")
  `PLE_ASSERT_NOW(a_full_len, rsp_valid_q && rsp_st_q == ple_pkg::ST_FULL,
    rsp_len_q == ple_pkg::CNT_W'(ple_pkg::CAPACITY), "full status below capacity")

endmodule
